// ===== sv/lqi_pkg.sv =====
package lqi_pkg;

   localparam int STATE_COUNT = 4;
   localparam int ELEM_MAX    = 4;
   localparam int IDX_W       = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_ROW     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_STATE_GAIN_ROW = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEGRAL_GAIN  = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEGRAL_LOW   = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_INTEGRAL_HIGH  = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_LOW      = CSR_ADDR_W'(5);
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_HIGH     = CSR_ADDR_W'(6);
   localparam logic [CSR_ADDR_W-1:0] CSR_GAINS_VALID    = CSR_ADDR_W'(7);

   // multiplier operand selects
   localparam logic [1:0] MA_X    = 2'd0;
   localparam logic [1:0] MA_ERR  = 2'd1;
   localparam logic [1:0] MA_INT  = 2'd2;
   localparam logic [1:0] MB_C    = 2'd0;
   localparam logic [1:0] MB_K    = 2'd1;
   localparam logic [1:0] MB_STEP = 2'd2;
   localparam logic [1:0] MB_KI   = 2'd3;

   // sequencer jump kinds
   localparam logic [1:0] JMP_NEXT   = 2'd0;
   localparam logic [1:0] JMP_LOOP   = 2'd1;
   localparam logic [1:0] JMP_NOGAIN = 2'd2;

   localparam int UPC_W = 4;
   localparam logic [UPC_W-1:0] UA_CMUL = UPC_W'(0);
   localparam logic [UPC_W-1:0] UA_KMUL = UPC_W'(1);
   localparam logic [UPC_W-1:0] UA_ERR  = UPC_W'(2);
   localparam logic [UPC_W-1:0] UA_DMUL = UPC_W'(3);
   localparam logic [UPC_W-1:0] UA_INT  = UPC_W'(4);
   localparam logic [UPC_W-1:0] UA_IMUL = UPC_W'(5);
   localparam logic [UPC_W-1:0] UA_KI   = UPC_W'(6);
   localparam logic [UPC_W-1:0] UA_SAT  = UPC_W'(7);
   localparam logic [UPC_W-1:0] UA_OUT  = UPC_W'(8);
   localparam logic [UPC_W-1:0] UA_ZERO = UPC_W'(9);

   localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
   localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

   typedef logic [ELEM_MAX-1:0][15:0] row_type;

   typedef struct packed {
      row_type            output_row;
      row_type            state_gain_row;
      logic signed [15:0] integral_gain;
      logic signed [31:0] integral_low;
      logic signed [31:0] integral_high;
      logic signed [15:0] drive_low;
      logic signed [15:0] drive_high;
      logic               gains_valid;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       a_sel;
      logic [1:0]       b_sel;
      logic             acc_y;
      logic             acc_k;
      logic             err;
      logic             integ;
      logic             ki;
      logic             u;
      logic             out;
      logic             zero;
      logic [1:0]       jmp;
      logic [UPC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic             start;
      logic [1:0]       a_sel;
      logic [1:0]       b_sel;
      logic [IDX_W-1:0] idx;
      logic             acc_y;
      logic             acc_k;
      logic             err;
      logic             integ;
      logic             ki;
      logic             u;
      logic             out;
      logic             zero;
   } ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = $signed(32'h80000000);
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // microprogram
   function automatic uword_type lqi_ucode(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '0;
      case (addr)
         UA_CMUL: begin
            w.a_sel  = MA_X;
            w.b_sel  = MB_C;
            w.acc_k  = 1'b1;
            w.jmp    = JMP_NOGAIN;
            w.target = UA_ZERO;
         end
         UA_KMUL: begin
            w.a_sel  = MA_X;
            w.b_sel  = MB_K;
            w.acc_y  = 1'b1;
            w.jmp    = JMP_LOOP;
            w.target = UA_CMUL;
         end
         UA_ERR: begin
            w.acc_k = 1'b1;
            w.err   = 1'b1;
         end
         UA_DMUL: begin
            w.a_sel = MA_ERR;
            w.b_sel = MB_STEP;
         end
         UA_INT: begin
            w.integ = 1'b1;
         end
         UA_IMUL: begin
            w.a_sel = MA_INT;
            w.b_sel = MB_KI;
         end
         UA_KI: begin
            w.ki = 1'b1;
         end
         UA_SAT: begin
            w.u = 1'b1;
         end
         UA_OUT: begin
            w.out = 1'b1;
         end
         UA_ZERO: begin
            w.zero = 1'b1;
         end
         default: begin
            w.zero = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/lqi_req_if.sv =====
interface lqi_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] state_0;
   logic signed [15:0] state_1;
   logic signed [15:0] state_2;
   logic signed [15:0] state_3;
   logic signed [15:0] setpoint;
   logic [15:0]        step_time;

   modport source (
      output valid, state_0, state_1, state_2, state_3, setpoint, step_time,
      input  ready
   );
   modport sink (
      input  valid, state_0, state_1, state_2, state_3, setpoint, step_time,
      output ready
   );
endinterface

// ===== sv/lqi_rsp_if.sv =====
interface lqi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] drive;
   logic signed [31:0] drive_unclamped;
   logic signed [31:0] tracking_error;
   logic signed [31:0] integral_value;

   modport source (
      output valid, drive, drive_unclamped, tracking_error, integral_value,
      input  ready
   );
   modport sink (
      input  valid, drive, drive_unclamped, tracking_error, integral_value,
      output ready
   );
endinterface

// ===== sv/lqi_csr_if.sv =====
interface lqi_csr_if import lqi_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ===== sv/lqi_csr.sv =====
module lqi_csr import lqi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_addr)
            CSR_OUTPUT_ROW:     cfg_in.output_row     = csr_data;
            CSR_STATE_GAIN_ROW: cfg_in.state_gain_row = csr_data;
            CSR_INTEGRAL_GAIN:  cfg_in.integral_gain  = $signed(csr_data[15:0]);
            CSR_INTEGRAL_LOW:   cfg_in.integral_low   = $signed(csr_data[31:0]);
            CSR_INTEGRAL_HIGH:  cfg_in.integral_high  = $signed(csr_data[31:0]);
            CSR_DRIVE_LOW:      cfg_in.drive_low      = $signed(csr_data[15:0]);
            CSR_DRIVE_HIGH:     cfg_in.drive_high     = $signed(csr_data[15:0]);
            CSR_GAINS_VALID:    cfg_in.gains_valid    = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_row     <= '0;
         cfg_ff.state_gain_row <= '0;
         cfg_ff.integral_gain  <= '0;
         cfg_ff.integral_low   <= $signed(32'h80000000);
         cfg_ff.integral_high  <= 32'sh7FFFFFFF;
         cfg_ff.drive_low      <= $signed(16'h8000);
         cfg_ff.drive_high     <= 16'sh7FFF;
         cfg_ff.gains_valid    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/lqi_useq.sv =====
module lqi_useq import lqi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  logic    gains_valid,
   output ctl_type ctl
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   uword_type        word;
   logic             accept;
   logic             finish;
   logic             stall;
   logic             commit;
   logic             last_elem;

   assign word      = lqi_ucode(pc_ff);
   assign accept    = req_valid && !busy_ff;
   assign finish    = busy_ff && (word.out || word.zero);
   assign stall     = finish && rsp_valid_ff && !rsp_ready;
   assign commit    = finish && !stall;
   assign last_elem = (idx_ff == IDX_W'(STATE_COUNT - 1));

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = UA_CMUL;
         idx_in  = '0;
      end else if (busy_ff && !finish) begin
         case (word.jmp)
            JMP_LOOP: begin
               if (!last_elem) begin
                  idx_in = idx_ff + IDX_W'(1);
                  pc_in  = word.target;
               end else begin
                  pc_in = pc_ff + UPC_W'(1);
               end
            end
            JMP_NOGAIN: begin
               pc_in = gains_valid ? pc_ff + UPC_W'(1) : word.target;
            end
            default: begin
               pc_in = pc_ff + UPC_W'(1);
            end
         endcase
      end
   end

   always_comb begin
      ctl       = '0;
      ctl.start = accept;
      ctl.a_sel = word.a_sel;
      ctl.b_sel = word.b_sel;
      ctl.idx   = idx_ff;
      ctl.acc_y = busy_ff && word.acc_y;
      ctl.acc_k = busy_ff && word.acc_k;
      ctl.err   = busy_ff && word.err;
      ctl.integ = busy_ff && word.integ;
      ctl.ki    = busy_ff && word.ki;
      ctl.u     = busy_ff && word.u;
      ctl.out   = commit && word.out;
      ctl.zero  = commit && word.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= UA_CMUL;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= UA_ZERO))
      else $error("sequencer left the program");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= IDX_W'(STATE_COUNT - 1)))
      else $error("element index out of range");

   a_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && pc_ff == UA_CMUL && idx_ff == '0))
      else $error("program did not start at its head");

   a_commit: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && !busy_ff))
      else $error("finished transaction not presented");

endmodule

// ===== sv/lqi_dpath.sv =====
module lqi_dpath import lqi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  cfg_type            cfg,
   input  row_type            req_state,
   input  logic signed [15:0] req_setpoint,
   input  logic [15:0]        req_step_time,
   output logic signed [15:0] rsp_drive,
   output logic signed [31:0] rsp_drive_unclamped,
   output logic signed [31:0] rsp_tracking_error,
   output logic signed [31:0] rsp_integral_value
);

   logic signed [15:0] x_ff [STATE_COUNT];
   logic signed [15:0] setpoint_ff;
   logic [15:0]        step_ff;
   logic signed [48:0] prod_ff;
   logic signed [33:0] acc_y_ff;
   logic signed [41:0] acc_k_ff;
   logic signed [31:0] err_ff;
   logic signed [31:0] integ_ff;
   logic signed [31:0] u_ff;
   logic signed [15:0] drive_ff;
   logic signed [31:0] out_u_ff;
   logic signed [31:0] out_err_ff;
   logic signed [31:0] out_integ_ff;

   logic signed [31:0] a_op;
   logic signed [16:0] b_op;
   logic signed [48:0] prod_in;
   logic signed [41:0] err_diff;
   logic signed [33:0] integ_sum;
   logic signed [33:0] integ_lo;
   logic signed [31:0] integ_in;
   logic signed [23:0] u_shift;
   logic signed [23:0] drive_lo;
   logic signed [15:0] drive_in;

   always_comb begin
      case (ctl.a_sel)
         MA_X:    a_op = 32'(x_ff[ctl.idx]);
         MA_ERR:  a_op = err_ff;
         MA_INT:  a_op = integ_ff;
         default: a_op = '0;
      endcase
      case (ctl.b_sel)
         MB_C:    b_op = 17'($signed(cfg.output_row[ctl.idx]));
         MB_K:    b_op = 17'($signed(cfg.state_gain_row[ctl.idx]));
         MB_STEP: b_op = $signed({1'b0, step_ff});
         MB_KI:   b_op = 17'(cfg.integral_gain);
         default: b_op = '0;
      endcase
   end

   assign prod_in = a_op * b_op;

   assign err_diff  = 42'($signed({setpoint_ff, 8'h00})) - 42'(acc_y_ff);
   assign integ_sum = 34'(integ_ff) + 34'($signed(prod_ff[48:16]));
   assign integ_lo  = (integ_sum < 34'(cfg.integral_low)) ? 34'(cfg.integral_low) : integ_sum;
   assign integ_in  = (integ_lo > 34'(cfg.integral_high)) ? cfg.integral_high
                                                         : integ_lo[31:0];
   assign u_shift   = $signed(u_ff[31:8]);
   assign drive_lo  = (u_shift < 24'(cfg.drive_low)) ? 24'(cfg.drive_low) : u_shift;
   assign drive_in  = (drive_lo > 24'(cfg.drive_high)) ? cfg.drive_high : drive_lo[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (ctl.integ) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         for (int i = 0; i < STATE_COUNT; i++) begin
            x_ff[i] <= $signed(req_state[i]);
         end
         setpoint_ff <= req_setpoint;
         step_ff     <= req_step_time;
         prod_ff     <= '0;
         acc_y_ff    <= '0;
         acc_k_ff    <= '0;
      end else begin
         prod_ff <= prod_in;
         if (ctl.acc_y) begin
            acc_y_ff <= acc_y_ff + 34'(prod_ff);
         end
         if (ctl.acc_k) begin
            acc_k_ff <= acc_k_ff + 42'(prod_ff);
         end else if (ctl.ki) begin
            acc_k_ff <= acc_k_ff + 42'($signed(prod_ff[48:8]));
         end
      end
      if (ctl.err) begin
         err_ff <= sat32(err_diff);
      end
      if (ctl.u) begin
         u_ff <= sat32(-acc_k_ff);
      end
      if (ctl.out) begin
         drive_ff     <= drive_in;
         out_u_ff     <= u_ff;
         out_err_ff   <= err_ff;
         out_integ_ff <= integ_ff;
      end else if (ctl.zero) begin
         drive_ff     <= '0;
         out_u_ff     <= '0;
         out_err_ff   <= '0;
         out_integ_ff <= '0;
      end
   end

   assign rsp_drive           = drive_ff;
   assign rsp_drive_unclamped = out_u_ff;
   assign rsp_tracking_error  = out_err_ff;
   assign rsp_integral_value  = out_integ_ff;

endmodule

// ===== sv/lqi_integral_state_feedback.sv =====
// channel  modport  transaction
// req_ch   sink     state_0..state_3, setpoint, step_time in
// rsp_ch   source   drive, drive_unclamped, tracking_error, integral_value out
// csr_ch   sink     register addr and data, always ready
//
// one shared 32x17 multiplier, driven by a microcode step counter
// an item steps the sequencer through CMUL and KMUL per element, then ERR, DMUL, INT, IMUL, KI, SAT and OUT
// with gains_valid low an item jumps from CMUL to ZERO and returns zeros
// a new request is taken while the previous result waits in the output register
// a stalled result holds the sequencer on its final step; reset is synchronous
module lqi_integral_state_feedback import lqi_pkg::*; (
   input logic     clock,
   input logic     reset,
   lqi_req_if.sink   req_ch,
   lqi_rsp_if.source rsp_ch,
   lqi_csr_if.sink   csr_ch
);

   cfg_type cfg;
   ctl_type ctl;
   row_type req_state;

   assign req_state[0] = req_ch.state_0;
   assign req_state[1] = req_ch.state_1;
   assign req_state[2] = req_ch.state_2;
   assign req_state[3] = req_ch.state_3;

   lqi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_addr  (csr_ch.addr),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   lqi_useq u_useq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .gains_valid (cfg.gains_valid),
      .ctl         (ctl)
   );

   lqi_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .cfg                 (cfg),
      .req_state           (req_state),
      .req_setpoint        (req_ch.setpoint),
      .req_step_time       (req_ch.step_time),
      .rsp_drive           (rsp_ch.drive),
      .rsp_drive_unclamped (rsp_ch.drive_unclamped),
      .rsp_tracking_error  (rsp_ch.tracking_error),
      .rsp_integral_value  (rsp_ch.integral_value)
   );

endmodule

// ===== test/lqi_integral_state_feedback_tb.sv =====
module lqi_integral_state_feedback_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lqi_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_UNUSED = CSR_GAINS_VALID + 1'b1;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 200;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE_CYCLES = 24;
   localparam int MAX_REPORTS  = 40;

   typedef struct packed {
      logic [ELEM_MAX-1:0][15:0] state;
      logic signed [15:0]        setpoint;
      logic [15:0]               step_time;
   } sample_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic signed [31:0] drive_unclamped;
      logic signed [31:0] tracking_error;
      logic signed [31:0] integral_value;
   } control_type;

   logic clock;
   logic reset;

   lqi_req_if req_if ();
   lqi_rsp_if rsp_if ();
   lqi_csr_if csr_if ();

   lqi_integral_state_feedback dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   cfg_type            model_cfg;
   logic signed [31:0] model_integral;
   control_type        pending_controls[$];

   bit calm;
   int hold_left;
   int samples_sent;
   int results_checked;
   int settings_applied;
   int mismatch_count;

   always #4 clock = ~clock;

   // control law predictor

   function automatic longint clip32(input longint v);
      if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
      if (v < -longint'(64'h80000000)) return -longint'(64'h80000000);
      return v;
   endfunction

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      longint r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic control_type predict_control(input sample_type s);
      control_type r;
      longint y, kx, err, delta, integ, ki, u, d;
      int i;
      r = '0;
      if (!model_cfg.gains_valid) return r;
      y = 0;
      kx = 0;
      for (i = 0; i < STATE_COUNT; i++) begin
         y  += longint'($signed(model_cfg.output_row[i])) * longint'($signed(s.state[i]));
         kx += longint'($signed(model_cfg.state_gain_row[i])) * longint'($signed(s.state[i]));
      end
      err   = clip32(longint'(s.setpoint) * 256 - y);
      delta = (err * longint'(s.step_time)) >>> 16;
      integ = limit(longint'(model_integral) + delta,
                    longint'($signed(model_cfg.integral_low)),
                    longint'($signed(model_cfg.integral_high)));
      model_integral = integ[31:0];
      ki = (longint'($signed(model_cfg.integral_gain)) * integ) >>> 8;
      u  = clip32(-(kx + ki));
      d  = limit(u >>> 8, longint'($signed(model_cfg.drive_low)),
                 longint'($signed(model_cfg.drive_high)));
      r.drive           = d[15:0];
      r.drive_unclamped = u[31:0];
      r.tracking_error  = err[31:0];
      r.integral_value  = integ[31:0];
      return r;
   endfunction

   function automatic void apply_register(input logic [CSR_ADDR_W-1:0] addr,
                                          input logic [CSR_DATA_W-1:0] data);
      case (addr)
         CSR_OUTPUT_ROW:     model_cfg.output_row     = data;
         CSR_STATE_GAIN_ROW: model_cfg.state_gain_row = data;
         CSR_INTEGRAL_GAIN:  model_cfg.integral_gain  = data[15:0];
         CSR_INTEGRAL_LOW:   model_cfg.integral_low   = data[31:0];
         CSR_INTEGRAL_HIGH:  model_cfg.integral_high  = data[31:0];
         CSR_DRIVE_LOW:      model_cfg.drive_low      = data[15:0];
         CSR_DRIVE_HIGH:     model_cfg.drive_high     = data[15:0];
         CSR_GAINS_VALID:    model_cfg.gains_valid    = data[0];
         default: ;
      endcase
   endfunction

   function automatic cfg_type reset_settings();
      cfg_type c;
      c = '0;
      c.integral_low  = 32'sh80000000;
      c.integral_high = 32'sh7FFFFFFF;
      c.drive_low     = 16'sh8000;
      c.drive_high    = 16'sh7FFF;
      return c;
   endfunction

   function automatic logic [15:0] near_zero(input int span);
      int v;
      v = int'($urandom_range(2 * span)) - span;
      return v[15:0];
   endfunction

   function automatic int spread32(input int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic cfg_type random_settings(input bit wide);
      cfg_type c;
      int a, b, i;
      c = reset_settings();
      for (i = 0; i < ELEM_MAX; i++) begin
         c.output_row[i]     = wide ? 16'($urandom) : near_zero(512);
         c.state_gain_row[i] = wide ? 16'($urandom) : near_zero(512);
      end
      c.integral_gain = wide ? 16'($urandom) : near_zero(512);
      a = spread32(1 << 24);
      b = spread32(1 << 24);
      case ($urandom_range(3))
         0: ;
         1: begin
            c.integral_low  = (a < b) ? a : b;
            c.integral_high = (a < b) ? b : a;
         end
         2: begin
            c.integral_low  = (a < b) ? b : a;
            c.integral_high = (a < b) ? a : b;
         end
         default: begin
            c.integral_low  = a;
            c.integral_high = a;
         end
      endcase
      a = spread32(1 << 12);
      b = spread32(1 << 12);
      case ($urandom_range(3))
         0: ;
         1: begin
            c.drive_low  = (a < b) ? a[15:0] : b[15:0];
            c.drive_high = (a < b) ? b[15:0] : a[15:0];
         end
         2: begin
            c.drive_low  = (a < b) ? b[15:0] : a[15:0];
            c.drive_high = (a < b) ? a[15:0] : b[15:0];
         end
         default: begin
            c.drive_low  = 16'($urandom);
            c.drive_high = 16'($urandom);
         end
      endcase
      c.gains_valid = ($urandom_range(7) != 0);
      return c;
   endfunction

   function automatic sample_type make_sample(input logic [15:0] x0, input logic [15:0] x1,
                                              input logic [15:0] x2, input logic [15:0] x3,
                                              input logic [15:0] sp, input logic [15:0] st);
      sample_type s;
      s.state     = {x3, x2, x1, x0};
      s.setpoint  = sp;
      s.step_time = st;
      return s;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int i;
      for (i = 0; i < ELEM_MAX; i++) begin
         s.state[i] = ($urandom_range(3) == 0) ? 16'($urandom) : near_zero(1024);
      end
      s.setpoint = $urandom_range(1) ? 16'($urandom) : near_zero(1024);
      case ($urandom_range(3))
         0: s.step_time = 16'($urandom);
         1: s.step_time = 16'($urandom_range(255));
         2: s.step_time = 16'($urandom_range(4095));
         default: s.step_time = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      return s;
   endfunction

   // channel drivers, all entered and left at a falling edge

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= addr;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_register(addr, data);
      @(negedge clock);
   endtask

   // upper bits of narrow registers carry junk
   task automatic configure(input cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      junk = {$urandom, $urandom};
      csr_write(CSR_OUTPUT_ROW, c.output_row);
      csr_write(CSR_STATE_GAIN_ROW, c.state_gain_row);
      csr_write(CSR_INTEGRAL_GAIN, {junk[63:16], c.integral_gain});
      csr_write(CSR_INTEGRAL_LOW, {junk[63:32], c.integral_low});
      csr_write(CSR_INTEGRAL_HIGH, {junk[31:0], c.integral_high});
      csr_write(CSR_DRIVE_LOW, {junk[47:0], c.drive_low});
      csr_write(CSR_DRIVE_HIGH, {junk[63:16], c.drive_high});
      csr_write(CSR_GAINS_VALID, {junk[63:1], c.gains_valid});
      csr_if.valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_sample(input sample_type s);
      while (!calm && $urandom_range(99) < 16) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.state_0   <= s.state[0];
      req_if.state_1   <= s.state[1];
      req_if.state_2   <= s.state[2];
      req_if.state_3   <= s.state[3];
      req_if.setpoint  <= s.setpoint;
      req_if.step_time <= s.step_time;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_controls.push_back(predict_control(s));
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      int waited;
      req_if.valid <= 1'b0;
      waited = 0;
      while (pending_controls.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_controls.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_controls.size()));
         pending_controls.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      control_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_controls.size() == 0) begin
            report_mismatch("result transaction with nothing pending");
         end else begin
            want = pending_controls.pop_front();
            check_field("drive", rsp_if.drive, want.drive);
            check_field("drive_unclamped", rsp_if.drive_unclamped, want.drive_unclamped);
            check_field("tracking_error", rsp_if.tracking_error, want.tracking_error);
            check_field("integral_value", rsp_if.integral_value, want.integral_value);
            results_checked++;
         end
      end
   end

   // result receiver with random stalls and an optional long hold
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 16);
         end
      end
   end

   // tests

   task automatic test_disabled_after_reset();
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF));
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      drain();
   endtask

   task automatic test_field_extremes();
      cfg_type c;
      c = reset_settings();
      c.output_row     = {ELEM_MAX{16'h7FFF}};
      c.state_gain_row = {ELEM_MAX{16'h8000}};
      c.integral_gain  = 16'sh7FFF;
      c.gains_valid    = 1'b1;
      configure(c);
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0001));
      send_sample(make_sample(16'h0001, 16'hFFFF, 16'h0100, 16'hFF00, 16'h0100, 16'h8000));
      drain();
      c.output_row     = {ELEM_MAX{16'h8000}};
      c.state_gain_row = {ELEM_MAX{16'h7FFF}};
      c.integral_gain  = 16'sh8000;
      configure(c);
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF));
      send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF));
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000));
      drain();
   endtask

   // integral must hold while gains are invalid
   task automatic test_gain_disable();
      cfg_type c;
      c = random_settings(1'b0);
      c.gains_valid = 1'b1;
      configure(c);
      send_sample(make_sample(16'h0100, 16'h0000, 16'hFF00, 16'h0000, 16'h0400, 16'h4000));
      send_sample(make_sample(16'h0100, 16'h0000, 16'hFF00, 16'h0000, 16'h0400, 16'h4000));
      drain();
      csr_write(CSR_GAINS_VALID, '0);
      csr_if.valid <= 1'b0;
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h1234, 16'h0042, 16'h8000, 16'h0000, 16'h0200, 16'h1000));
      drain();
      csr_write(CSR_GAINS_VALID, 64'd1);
      csr_if.valid <= 1'b0;
      send_sample(make_sample(16'h0100, 16'h0000, 16'hFF00, 16'h0000, 16'h0400, 16'h4000));
      drain();
   endtask

   task automatic test_crossed_limits();
      cfg_type c;
      c = random_settings(1'b0);
      c.integral_low  = 32'sd1000;
      c.integral_high = -32'sd1000;
      c.drive_low     = 16'sd100;
      c.drive_high    = -16'sd100;
      c.gains_valid   = 1'b1;
      configure(c);
      send_sample(make_sample(16'h0100, 16'h0200, 16'h0000, 16'hFF00, 16'h0800, 16'hFFFF));
      send_sample(make_sample(16'hF000, 16'h0200, 16'h0100, 16'h0000, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      drain();
   endtask

   task automatic test_unused_registers();
      int a;
      for (a = CSR_FIRST_UNUSED; a < 2 ** CSR_ADDR_W; a++) begin
         csr_write(CSR_ADDR_W'(a), {$urandom, $urandom});
      end
      csr_if.valid <= 1'b0;
      send_sample(random_sample());
      send_sample(random_sample());
      drain();
   endtask

   task automatic test_output_stall();
      cfg_type c;
      int i;
      c = random_settings(1'b0);
      c.gains_valid = 1'b1;
      configure(c);
      hold_left = 300;
      for (i = 0; i < 30; i++) send_sample(random_sample());
      drain();
   endtask

   task automatic test_random_phases();
      cfg_type c;
      int p, i;
      for (p = 0; p < PHASE_COUNT; p++) begin
         c = random_settings(p % 2 == 0);
         if (p == 0) c.gains_valid = 1'b1;
         calm = (p == 3);
         configure(c);
         for (i = 0; i < PHASE_ITEMS; i++) send_sample(random_sample());
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      hold_left = 0;
      samples_sent = 0;
      results_checked = 0;
      settings_applied = 0;
      mismatch_count = 0;
      model_cfg = reset_settings();
      model_integral = '0;
      req_if.valid = 1'b0;
      req_if.state_0 = '0;
      req_if.state_1 = '0;
      req_if.state_2 = '0;
      req_if.state_3 = '0;
      req_if.setpoint = '0;
      req_if.step_time = '0;
      csr_if.valid = 1'b0;
      csr_if.addr = '0;
      csr_if.data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_disabled_after_reset();
      test_field_extremes();
      test_gain_disable();
      test_crossed_limits();
      test_unused_registers();
      test_output_stall();
      test_random_phases();

      $display("ran %0d samples under %0d register settings, checked %0d results",
               samples_sent, settings_applied, results_checked);
      $display("included disabled gains, crossed clamps, unused indexes and a long output stall");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("timeout with %0d results pending", pending_controls.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lqi_pkg.sv
sv/lqi_req_if.sv
sv/lqi_rsp_if.sv
sv/lqi_csr_if.sv
sv/lqi_csr.sv
sv/lqi_useq.sv
sv/lqi_dpath.sv
sv/lqi_integral_state_feedback.sv
test/lqi_integral_state_feedback_tb.sv
